// ----- src/cle_pkg.sv -----
// Shared definitions for the console line editor: action and result kind
// codes, terminal control characters and the result item type.
// Depends on nothing; imported by console_line_editor_top only.
`timescale 1ns / 1ps

package cle_pkg;

    // Input action codes
    localparam logic [1:0] ACT_RX    = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_ERROR = 2'd2;

    // Result kind codes
    localparam logic [2:0] KIND_ECHO    = 3'd0;
    localparam logic [2:0] KIND_ERASE   = 3'd1;
    localparam logic [2:0] KIND_LINE    = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_NO_LINE = 3'd4;
    localparam logic [2:0] KIND_REFUSED = 3'd5;

    // Terminal control characters
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Largest erase run reported in one result item
    localparam int unsigned MAX_ERASE_RUN = 255;

    // One result item as held in the output register
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [7:0] erase_count;
        logic       last;
    } cle_result_t;

endpackage

// ----- src/console_line_editor_top.sv -----
// Top level of the console line editor: editing and delivery control,
// result staging and the output register.
// Depends on cle_pkg and cle_line_store.
`timescale 1ns / 1ps

// Console line editor. Each input item (received byte, read request or
// receive error) acts on the editing state as soon as it is accepted, so
// one item can be taken every clock while input is not refused. An item
// leaves zero or one result, except CR or LF, which leaves two (CR echo,
// then LF echo) and holds the staging register until the LF echo moves
// on. A delivered line byte is read from the single read port of the line
// store at the same edge that accepts the read request and loads the
// staging register, so it is ready when the result moves on. Every result
// passes through the staging register and then the output register, where
// it stays until it is taken. Input is refused only while the staging
// register holds a result that the output cannot yet take, including the
// cycle in which the CR echo of a pair moves on. The line store is never
// cleared: delivery only reads entries written for the current line.
module console_line_editor_top #(
    parameter int LINE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] out_byte,
    output logic [7:0] erase_count,
    output logic       last
);
    import cle_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int FW = $clog2(LINE_DEPTH + 1);

    // Editing and delivery state
    logic [FW-1:0] fill_count_reg, fill_count_next;
    logic [FW-1:0] remaining_reg, remaining_next;
    logic [AW-1:0] read_index_reg, read_index_next;
    logic          delivering_reg, delivering_next;

    // Staging register: result decided at acceptance
    logic       s1_valid_reg;
    logic [2:0] s1_kind_reg;
    logic [7:0] s1_byte_reg;
    logic [7:0] s1_count_reg;
    logic       s1_pair_reg;
    logic       s1_mem_reg;

    // Output register
    logic        out_valid_reg;
    cle_result_t out_reg;

    // Decode results
    logic        in_fire;
    logic        ld;
    logic [2:0]  ld_kind;
    logic [7:0]  ld_byte;
    logic [7:0]  ld_count;
    logic        ld_pair;
    logic        ld_mem;
    logic        wr_en;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [7:0]  rd_data;
    logic [FW-1:0] erase_n;
    logic [FW-1:0] fill_after_nl;

    // Handshake
    logic out_free;
    logic s1_move;
    logic s1_done;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_done  = s1_move && !s1_pair_reg;
    assign in_ready = !s1_valid_reg || s1_done;
    assign in_fire  = in_valid && in_ready;

    // Erase run length for Ctrl-U, capped at one run
    assign erase_n = (32'(fill_count_reg) > 32'(MAX_ERASE_RUN)) ?
                     FW'(MAX_ERASE_RUN) : fill_count_reg;

    // Fill after storing a newline, if there is room
    assign fill_after_nl = (fill_count_reg < FW'(LINE_DEPTH)) ?
                           fill_count_reg + FW'(1) : fill_count_reg;

    // Decide the item's effect on the state and its result
    always_comb
    begin
        fill_count_next = fill_count_reg;
        remaining_next  = remaining_reg;
        read_index_next = read_index_reg;
        delivering_next = delivering_reg;
        ld       = 1'b0;
        ld_kind  = KIND_ECHO;
        ld_byte  = 8'd0;
        ld_count = 8'd0;
        ld_pair  = 1'b0;
        ld_mem   = 1'b0;
        wr_en    = 1'b0;
        wr_data  = rx_byte;
        rd_en    = 1'b0;

        if (in_fire)
        begin
            if (delivering_reg)
            begin
                case (action)
                    ACT_RX:
                    begin
                        ld      = 1'b1;
                        ld_kind = KIND_REFUSED;
                    end
                    ACT_READ:
                    begin
                        ld = 1'b1;
                        if (remaining_reg == '0)
                        begin
                            ld_kind         = KIND_END;
                            delivering_next = 1'b0;
                            read_index_next = '0;
                        end
                        else
                        begin
                            ld_kind         = KIND_LINE;
                            ld_mem          = 1'b1;
                            rd_en           = 1'b1;
                            remaining_next  = remaining_reg - FW'(1);
                            read_index_next = read_index_reg + AW'(1);
                            if (remaining_reg == FW'(1))
                            begin
                                delivering_next = 1'b0;
                                read_index_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        // receive error and unused code: drop
                    end
                endcase
            end
            else
            begin
                case (action)
                    ACT_READ:
                    begin
                        ld      = 1'b1;
                        ld_kind = KIND_NO_LINE;
                    end
                    ACT_ERROR:
                    begin
                        remaining_next  = fill_count_reg;
                        read_index_next = '0;
                        fill_count_next = '0;
                        delivering_next = 1'b1;
                    end
                    ACT_RX:
                    begin
                        if (rx_byte == CH_EOT)
                        begin
                            remaining_next  = fill_count_reg;
                            read_index_next = '0;
                            fill_count_next = '0;
                            delivering_next = 1'b1;
                        end
                        else if (rx_byte inside {CH_CR, CH_LF})
                        begin
                            wr_en           = (fill_count_reg < FW'(LINE_DEPTH));
                            wr_data         = CH_LF;
                            remaining_next  = fill_after_nl;
                            read_index_next = '0;
                            fill_count_next = '0;
                            delivering_next = 1'b1;
                            ld              = 1'b1;
                            ld_kind         = KIND_ECHO;
                            ld_byte         = CH_CR;
                            ld_pair         = 1'b1;
                        end
                        else if (rx_byte inside {CH_BS, CH_DEL})
                        begin
                            if (fill_count_reg != '0)
                            begin
                                fill_count_next = fill_count_reg - FW'(1);
                                ld              = 1'b1;
                                ld_kind         = KIND_ERASE;
                                ld_count        = 8'd1;
                            end
                        end
                        else if (rx_byte == CH_NAK)
                        begin
                            if (fill_count_reg != '0)
                            begin
                                fill_count_next = fill_count_reg - erase_n;
                                ld              = 1'b1;
                                ld_kind         = KIND_ERASE;
                                ld_count        = 8'(erase_n);
                            end
                        end
                        else if (fill_count_reg >= FW'(LINE_DEPTH - 1))
                        begin
                            ld      = 1'b1;
                            ld_kind = KIND_ECHO;
                            ld_byte = CH_BEL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            fill_count_next = fill_count_reg + FW'(1);
                            ld              = 1'b1;
                            ld_kind         = KIND_ECHO;
                            ld_byte         = rx_byte;
                        end
                    end
                    default:
                    begin
                        // unused action code: drop
                    end
                endcase
            end
        end
    end

    // Line store
    cle_line_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (read_index_reg),
        .rd_data (rd_data)
    );

    // Advance the editing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            remaining_reg  <= '0;
            read_index_reg <= '0;
            delivering_reg <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            remaining_reg  <= remaining_next;
            read_index_reg <= read_index_next;
            delivering_reg <= delivering_next;
        end
    end

    // Staging register control: load on a new item, turn CR into LF after
    // the first of a pair moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pair_reg  <= 1'b0;
        end
        else if (ld)
        begin
            s1_valid_reg <= 1'b1;
            s1_pair_reg  <= ld_pair;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= s1_pair_reg;
            s1_pair_reg  <= 1'b0;
        end
    end

    // Staging register payload
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            s1_kind_reg  <= ld_kind;
            s1_byte_reg  <= ld_byte;
            s1_count_reg <= ld_count;
            s1_mem_reg   <= ld_mem;
        end
        else if (s1_move && s1_pair_reg)
        begin
            s1_byte_reg <= CH_LF;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Output register payload; line bytes come from the store's read data
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg.kind        <= s1_kind_reg;
            out_reg.out_byte    <= s1_mem_reg ? rd_data : s1_byte_reg;
            out_reg.erase_count <= s1_count_reg;
            out_reg.last        <= !s1_pair_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign out_byte    = out_reg.out_byte;
    assign erase_count = out_reg.erase_count;
    assign last        = out_reg.last;

    // A pending LF always sits in a valid staging register
    a_pair_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_pair_reg |-> s1_valid_reg)
        else $error("pending LF without a staged result");

    // Delivery starts with an empty edit buffer and keeps it empty
    a_fill_clear_in_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        delivering_reg |-> fill_count_reg == '0)
        else $error("edit buffer not empty during delivery");

    // Read pointer rests at zero while editing
    a_read_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !delivering_reg |-> read_index_reg == '0)
        else $error("read pointer moved while editing");

    // Delivery never runs past the end of the store
    a_delivery_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(read_index_reg) + 32'(remaining_reg)) <= 32'(LINE_DEPTH))
        else $error("delivery would read past the line store");

    // A loaded line byte is staged with the flag that takes the store's read data
    a_line_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ld && ld_mem |=> s1_valid_reg && s1_mem_reg)
        else $error("line byte lost from staging register");

endmodule

// ----- src/cle_line_store.sv -----
// Line store of the console line editor: one write port and one read port
// with registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module cle_line_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
